@@ rtl/uart_rb_pkg.sv @@
// uart_rb_pkg: shared types and constants for the uart ring buffer block
// holds action codes, register indexes, flow characters and the status struct
// no dependencies
package uart_rb_pkg;

    // action codes of one input transaction
    typedef enum logic [2:0] {
        ACT_RX_BYTE    = 3'd0,
        ACT_HOST_READ  = 3'd1,
        ACT_HOST_WRITE = 3'd2,
        ACT_TX_SLOT    = 3'd3,
        ACT_FLUSH      = 3'd4,
        ACT_CANCEL     = 3'd5
    } t_action;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_FLOW_MODE  = 2'd0,
        REG_HIGH_WATER = 2'd1,
        REG_LOW_WATER  = 2'd2
    } t_cfg_reg;

    // flow and cancel characters
    localparam logic [7:0] CH_XON  = 8'h11;
    localparam logic [7:0] CH_XOFF = 8'h13;
    localparam logic [7:0] CH_CAN  = 8'h18;

    // configuration reset values
    localparam logic       FLOW_MODE_RST  = 1'b0;
    localparam logic [7:0] HIGH_WATER_RST = 8'd192;
    localparam logic [7:0] LOW_WATER_RST  = 8'd64;

    // source of the result byte
    typedef enum logic [2:0] {
        SEL_NONE,
        SEL_RX_RAM,
        SEL_TX_RAM,
        SEL_XON,
        SEL_XOFF
    } t_byte_sel;

    typedef struct packed {
        logic       flow_mode;
        logic [7:0] high_water;
        logic [7:0] low_water;
    } t_cfg;

    // status of one step, registered as the result
    typedef struct packed {
        logic       out_valid;
        t_byte_sel  byte_sel;
        logic       rx_empty;
        logic       tx_rejected;
        logic       rts_stop;
        logic       overflow_flag;
        logic [8:0] rx_free;
        logic       tx_pending;
    } t_status;

endpackage

@@ rtl/uart_rb_if.sv @@
// uart_rb_if: valid/ready channel interfaces for input, result and config
// depends on nothing; used by uart_ring_buffers_with_flow_control_top

// input transaction channel
interface uart_rb_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [7:0] data_byte;
    logic       rt_taken;

    modport source (output valid, action, data_byte, rt_taken, input ready);
    modport sink (input valid, action, data_byte, rt_taken, output ready);
endinterface

// result transaction channel
interface uart_rb_out_if;
    logic       valid;
    logic       ready;
    logic       out_valid;
    logic [7:0] out_byte;
    logic       rx_empty;
    logic       tx_rejected;
    logic       rts_stop;
    logic       overflow_flag;
    logic [8:0] rx_free;
    logic       tx_pending;

    modport source (output valid, out_valid, out_byte, rx_empty, tx_rejected, rts_stop,
                    overflow_flag, rx_free, tx_pending, input ready);
    modport sink (input valid, out_valid, out_byte, rx_empty, tx_rejected, rts_stop,
                  overflow_flag, rx_free, tx_pending, output ready);
endinterface

// configuration write channel
interface uart_rb_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/uart_ring_buffers_with_flow_control_top.sv @@
// a result is registered and valid in the cycle after its input transaction is accepted
// throughput: one transaction per cycle while no result is held or o_out.ready is high;
// the result register frees as it is taken; the byte stores are rams with registered read, read at the accepting edge
// reset: ring pointers zero, rts released, overflow clear, xon counted as sent,
// config back to rts mode with watermarks 192 and 64; store contents undefined
module uart_ring_buffers_with_flow_control_top #(
    parameter int RX_DEPTH = 256,
    parameter int TX_DEPTH = 128
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    uart_rb_in_if.sink           i_in,
    uart_rb_out_if.source        o_out,
    uart_rb_cfg_if.sink          i_cfg
);

    uart_rb_pkg::t_cfg    r_cfg;
    uart_rb_pkg::t_status r_res;
    uart_rb_pkg::t_status status;
    logic                 r_valid;
    logic                 accept;
    logic [7:0]           rx_rdata, tx_rdata;

    // configuration writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.flow_mode  <= uart_rb_pkg::FLOW_MODE_RST;
            r_cfg.high_water <= uart_rb_pkg::HIGH_WATER_RST;
            r_cfg.low_water  <= uart_rb_pkg::LOW_WATER_RST;
        end else if (i_cfg.valid) begin
            unique case (uart_rb_pkg::t_cfg_reg'(i_cfg.index))
                uart_rb_pkg::REG_FLOW_MODE:  r_cfg.flow_mode  <= i_cfg.data[0];
                uart_rb_pkg::REG_HIGH_WATER: r_cfg.high_water <= i_cfg.data;
                uart_rb_pkg::REG_LOW_WATER:  r_cfg.low_water  <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    // input handshake, result register frees as it is taken
    assign i_in.ready = !r_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    uart_rb_ctrl #(
        .RX_DEPTH (RX_DEPTH),
        .TX_DEPTH (TX_DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_action    (i_in.action),
        .i_data_byte (i_in.data_byte),
        .i_rt_taken  (i_in.rt_taken),
        .i_cfg       (r_cfg),
        .o_status    (status),
        .o_rx_rdata  (rx_rdata),
        .o_tx_rdata  (tx_rdata)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= status;
        end
    end

    // result byte from the ram read registers or a flow character
    always_comb begin
        unique case (r_res.byte_sel)
            uart_rb_pkg::SEL_RX_RAM: o_out.out_byte = rx_rdata;
            uart_rb_pkg::SEL_TX_RAM: o_out.out_byte = tx_rdata;
            uart_rb_pkg::SEL_XON:    o_out.out_byte = uart_rb_pkg::CH_XON;
            uart_rb_pkg::SEL_XOFF:   o_out.out_byte = uart_rb_pkg::CH_XOFF;
            default:                 o_out.out_byte = 8'd0;
        endcase
    end

    assign o_out.valid         = r_valid;
    assign o_out.out_valid     = r_res.out_valid;
    assign o_out.rx_empty      = r_res.rx_empty;
    assign o_out.tx_rejected   = r_res.tx_rejected;
    assign o_out.rts_stop      = r_res.rts_stop;
    assign o_out.overflow_flag = r_res.overflow_flag;
    assign o_out.rx_free       = r_res.rx_free;
    assign o_out.tx_pending    = r_res.tx_pending;

    // a host read returns either a byte or the empty status, never both
    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(accept) &&
        $past(i_in.action) == uart_rb_pkg::ACT_HOST_READ
        |-> r_res.out_valid != r_res.rx_empty)
        else $error("host read result is inconsistent");

    // only a host write can be rejected
    a_reject_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(accept) &&
        $past(i_in.action) != uart_rb_pkg::ACT_HOST_WRITE
        |-> !r_res.tx_rejected)
        else $error("rejection reported for a non-write transaction");

    // overflow flag stays set until reset
    a_overflow_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(r_valid) && $past(r_res.overflow_flag)
        |-> r_res.overflow_flag)
        else $error("overflow flag cleared without reset");

endmodule

@@ rtl/uart_rb_ram.sv @@
// uart_rb_ram: generic single write port ram with registered read
// no dependencies
module uart_rb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port, read data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/uart_rb_ctrl.sv @@
// uart_rb_ctrl: ring pointers, flow control state and the two byte stores
// depends on uart_rb_pkg and uart_rb_ram
module uart_rb_ctrl #(
    parameter int RX_DEPTH = 256,
    parameter int TX_DEPTH = 128
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [2:0]            i_action,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_rt_taken,
    input  uart_rb_pkg::t_cfg     i_cfg,
    output uart_rb_pkg::t_status  o_status,
    output logic [7:0]            o_rx_rdata,
    output logic [7:0]            o_tx_rdata
);

    localparam int RXW  = $clog2(RX_DEPTH);
    localparam int TXW  = $clog2(TX_DEPTH);
    localparam int RXCW = $clog2(RX_DEPTH + 1);
    localparam int CMPW = (RXCW > 8) ? RXCW : 8;

    typedef enum logic [1:0] {
        PH_XON_PEND  = 2'd0,
        PH_XOFF_PEND = 2'd1,
        PH_XON_SENT  = 2'd2,
        PH_XOFF_SENT = 2'd3
    } t_phase;

    logic [RXW-1:0] r_rx_wr, r_rx_rd, n_rx_wr, n_rx_rd;
    logic [TXW-1:0] r_tx_wr, r_tx_rd, n_tx_wr, n_tx_rd;
    logic           r_rts, n_rts;
    logic           r_lost, n_lost;
    t_phase         r_phase, n_phase;

    logic [RXW-1:0]  rx_wr_inc, rx_rd_inc;
    logic [TXW-1:0]  tx_wr_inc, tx_rd_inc;
    logic [RXCW-1:0] cnt_old, cnt_new;
    logic            rx_full, rx_empty, tx_full, tx_empty, flow_pend;
    logic            rx_we, rx_re, tx_we, tx_re;
    logic [7:0]      rx_wdata;
    logic            st_valid, st_empty, st_rej;
    uart_rb_pkg::t_byte_sel st_sel;

    // pointer increments with wrap at the ring size
    assign rx_wr_inc = (r_rx_wr == RXW'(RX_DEPTH - 1)) ? '0 : r_rx_wr + 1'b1;
    assign rx_rd_inc = (r_rx_rd == RXW'(RX_DEPTH - 1)) ? '0 : r_rx_rd + 1'b1;
    assign tx_wr_inc = (r_tx_wr == TXW'(TX_DEPTH - 1)) ? '0 : r_tx_wr + 1'b1;
    assign tx_rd_inc = (r_tx_rd == TXW'(TX_DEPTH - 1)) ? '0 : r_tx_rd + 1'b1;

    // ring occupancy before the step
    assign cnt_old = (r_rx_wr >= r_rx_rd) ? RXCW'(r_rx_wr) - RXCW'(r_rx_rd)
                                          : RXCW'(r_rx_wr) + RXCW'(RX_DEPTH) - RXCW'(r_rx_rd);
    assign rx_full   = (rx_wr_inc == r_rx_rd);
    assign rx_empty  = (r_rx_rd == r_rx_wr);
    assign tx_full   = (tx_wr_inc == r_tx_rd);
    assign tx_empty  = (r_tx_rd == r_tx_wr);
    assign flow_pend = i_cfg.flow_mode && (r_phase == PH_XON_PEND || r_phase == PH_XOFF_PEND);

    // next state for one transaction
    always_comb begin
        n_rx_wr  = r_rx_wr;
        n_rx_rd  = r_rx_rd;
        n_tx_wr  = r_tx_wr;
        n_tx_rd  = r_tx_rd;
        n_rts    = r_rts;
        n_lost   = r_lost;
        n_phase  = r_phase;
        cnt_new  = cnt_old;
        rx_we    = 1'b0;
        rx_re    = 1'b0;
        tx_we    = 1'b0;
        tx_re    = 1'b0;
        rx_wdata = i_data_byte;
        st_valid = 1'b0;
        st_empty = 1'b0;
        st_rej   = 1'b0;
        st_sel   = uart_rb_pkg::SEL_NONE;
        unique case (uart_rb_pkg::t_action'(i_action))
            uart_rb_pkg::ACT_RX_BYTE: begin
                if (rx_full) begin
                    n_lost = 1'b1;
                end else begin
                    if (!i_rt_taken) begin
                        rx_we   = 1'b1;
                        n_rx_wr = rx_wr_inc;
                        cnt_new = cnt_old + RXCW'(1);
                    end
                    if (i_cfg.flow_mode) begin
                        if (r_phase == PH_XON_SENT &&
                            CMPW'(cnt_new) > CMPW'(i_cfg.high_water)) begin
                            n_phase = PH_XOFF_PEND;
                        end
                    end else if (CMPW'(cnt_new) >= CMPW'(i_cfg.high_water)) begin
                        n_rts = 1'b1;
                    end
                end
            end
            uart_rb_pkg::ACT_HOST_READ: begin
                if (rx_empty) begin
                    st_empty = 1'b1;
                end else begin
                    st_valid = 1'b1;
                    st_sel   = uart_rb_pkg::SEL_RX_RAM;
                    rx_re    = 1'b1;
                    n_rx_rd  = rx_rd_inc;
                    cnt_new  = cnt_old - RXCW'(1);
                    if (i_cfg.flow_mode) begin
                        if (r_phase == PH_XOFF_SENT &&
                            CMPW'(cnt_new) < CMPW'(i_cfg.low_water)) begin
                            n_phase = PH_XON_PEND;
                        end
                    end else if (CMPW'(cnt_new) < CMPW'(i_cfg.low_water)) begin
                        n_rts = 1'b0;
                    end
                end
            end
            uart_rb_pkg::ACT_HOST_WRITE: begin
                if (tx_full) begin
                    st_rej = 1'b1;
                end else begin
                    tx_we   = 1'b1;
                    n_tx_wr = tx_wr_inc;
                end
            end
            uart_rb_pkg::ACT_TX_SLOT: begin
                if (flow_pend) begin
                    st_valid = 1'b1;
                    if (r_phase == PH_XON_PEND) begin
                        st_sel  = uart_rb_pkg::SEL_XON;
                        n_phase = PH_XON_SENT;
                    end else begin
                        st_sel  = uart_rb_pkg::SEL_XOFF;
                        n_phase = PH_XOFF_SENT;
                    end
                end else if (!tx_empty) begin
                    st_valid = 1'b1;
                    st_sel   = uart_rb_pkg::SEL_TX_RAM;
                    tx_re    = 1'b1;
                    n_tx_rd  = tx_rd_inc;
                end
            end
            uart_rb_pkg::ACT_FLUSH: begin
                n_rx_wr = '0;
                n_rx_rd = '0;
                n_rts   = 1'b0;
                cnt_new = '0;
            end
            uart_rb_pkg::ACT_CANCEL: begin
                rx_we    = 1'b1;
                rx_wdata = uart_rb_pkg::CH_CAN;
                n_rx_rd  = r_rx_wr;
                n_rx_wr  = rx_wr_inc;
                n_rts    = 1'b0;
                cnt_new  = RXCW'(1);
            end
            default: begin
            end
        endcase
    end

    // status after the step
    always_comb begin
        o_status.out_valid     = st_valid;
        o_status.byte_sel      = st_sel;
        o_status.rx_empty      = st_empty;
        o_status.tx_rejected   = st_rej;
        o_status.rts_stop      = n_rts;
        o_status.overflow_flag = n_lost;
        o_status.rx_free       = 9'(RXCW'(RX_DEPTH) - cnt_new);
        o_status.tx_pending    = (n_tx_rd != n_tx_wr) ||
                                 (i_cfg.flow_mode &&
                                  (n_phase == PH_XON_PEND || n_phase == PH_XOFF_PEND));
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_wr <= '0;
            r_rx_rd <= '0;
            r_tx_wr <= '0;
            r_tx_rd <= '0;
            r_rts   <= 1'b0;
            r_lost  <= 1'b0;
            r_phase <= PH_XON_SENT;
        end else if (i_accept) begin
            r_rx_wr <= n_rx_wr;
            r_rx_rd <= n_rx_rd;
            r_tx_wr <= n_tx_wr;
            r_tx_rd <= n_tx_rd;
            r_rts   <= n_rts;
            r_lost  <= n_lost;
            r_phase <= n_phase;
        end
    end

    // receive store
    uart_rb_ram #(
        .WIDTH (8),
        .DEPTH (RX_DEPTH)
    ) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (i_accept && rx_we),
        .i_waddr (r_rx_wr),
        .i_wdata (rx_wdata),
        .i_re    (i_accept && rx_re),
        .i_raddr (r_rx_rd),
        .o_rdata (o_rx_rdata)
    );

    // transmit store
    uart_rb_ram #(
        .WIDTH (8),
        .DEPTH (TX_DEPTH)
    ) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (i_accept && tx_we),
        .i_waddr (r_tx_wr),
        .i_wdata (i_data_byte),
        .i_re    (i_accept && tx_re),
        .i_raddr (r_tx_rd),
        .o_rdata (o_tx_rdata)
    );

endmodule
